/* sv/srdcp_pkg.sv */
// ----------------------------------------------------------------------------
// srdcp_pkg
// shared types and constants of the serial rgb duty command parser
// ----------------------------------------------------------------------------
`default_nettype none

package srdcp_pkg;

  // bytes kept per line is LINE_CAPACITY - 1
  localparam int unsigned LINE_CAPACITY = 16;
  localparam int unsigned CNT_W         = $clog2(LINE_CAPACITY);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_CAPACITY - 1);

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DUTY_W = 7;
  localparam int unsigned MAG_W  = 7;
  // magnitude * 10 + digit for magnitude up to saturation
  localparam int unsigned ACC_W  = 10;

  localparam logic [MAG_W-1:0]  MAG_SAT  = MAG_W'(101);
  localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(100);

  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CHAR_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_R     = 8'h52;
  localparam logic [BYTE_W-1:0] CHAR_G     = 8'h47;
  localparam logic [BYTE_W-1:0] CHAR_B     = 8'h42;
  // clears the lower-case bit of a letter
  localparam logic [BYTE_W-1:0] UPPER_MASK = 8'hDF;

  typedef enum logic [1:0] {
    PHASE_SPACE  = 2'd0,
    PHASE_DIGITS = 2'd1,
    PHASE_DONE   = 2'd2
  } phase_e;

  typedef enum logic {
    STATUS_APPLIED     = 1'b0,
    STATUS_BAD_LETTER  = 1'b1
  } status_e;

endpackage

`default_nettype wire

/* sv/srdcp_in_if.sv */
// ----------------------------------------------------------------------------
// srdcp_in_if
// received byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface srdcp_in_if;
  import srdcp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* sv/srdcp_out_if.sv */
// ----------------------------------------------------------------------------
// srdcp_out_if
// command result channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface srdcp_out_if;
  import srdcp_pkg::*;

  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] red_duty;
  logic [DUTY_W-1:0] green_duty;
  logic [DUTY_W-1:0] blue_duty;
  logic              status;

  modport source (
    output valid, output red_duty, output green_duty, output blue_duty,
    output status, input ready
  );
  modport sink (
    input valid, input red_duty, input green_duty, input blue_duty,
    input status, output ready
  );
endinterface

`default_nettype wire

/* sv/serial_rgb_duty_command_parser_unit.sv */
// ----------------------------------------------------------------------------
// serial_rgb_duty_command_parser_unit
// parses "letter number" command lines from a byte stream into rgb duties
// ----------------------------------------------------------------------------
// usage
//   rx_i  : one received byte per transaction; cr or lf closes a line
//   res_o : one transaction per non-empty line, carrying the three current
//           duties (0..100) and a status bit (1 = unknown command letter,
//           duties left as they were)
//   a byte takes two stages: an input register, then the parse step that
//   updates the line state and the duty registers and fills the result
//   register, so a result is offered once its line end has passed the
//   input register and the parse step, and is taken on a res_o handshake
//   throughput is one byte per cycle while res_o takes results, bound by
//   the parse step; the parse step for a byte depends only on the state
//   left by the byte before it
//   when res_o stalls with a result pending, the parse step holds, the
//   input register fills and then rx_i.ready drops until the result leaves
//   reset clears the line state, the duties and both valid flags; no
//   result is pending after reset
// ----------------------------------------------------------------------------
`default_nettype none

module serial_rgb_duty_command_parser_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  srdcp_in_if.sink           rx_i,
  srdcp_out_if.source        res_o
);
  import srdcp_pkg::*;

  // input stage
  logic              byte_vld_q, byte_vld_d;
  logic [BYTE_W-1:0] byte_q;

  // line state
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [BYTE_W-1:0] letter_q, letter_d;
  phase_e            phase_q, phase_d;
  logic              neg_q, neg_d;
  logic [MAG_W-1:0]  mag_q, mag_d;

  // duty levels, also the duty fields of the result
  logic [DUTY_W-1:0] red_q, red_d;
  logic [DUTY_W-1:0] green_q, green_d;
  logic [DUTY_W-1:0] blue_q, blue_d;

  // result stage
  logic              res_vld_q, res_vld_d;
  status_e           status_q, status_d;

  logic              advance;
  logic              proc;
  logic              is_eol;
  logic              is_space;
  logic              is_sign;
  logic              is_digit;
  logic [ACC_W-1:0]  mag_ext;
  logic [ACC_W-1:0]  acc;
  logic [MAG_W-1:0]  mag_next;
  logic [DUTY_W-1:0] duty;
  logic [BYTE_W-1:0] letter_up;
  logic              emit;

  // parse step moves when the result register is free or being emptied
  assign advance    = !res_vld_q || res_o.ready;
  assign rx_i.ready = !byte_vld_q || advance;
  assign proc       = byte_vld_q && advance;

  assign byte_vld_d = (rx_i.valid && rx_i.ready) ? 1'b1
                    : (advance ? 1'b0 : byte_vld_q);

  // byte classes
  assign is_eol   = (byte_q == CHAR_CR) || (byte_q == CHAR_LF);
  assign is_space = (byte_q == CHAR_SPACE) || (byte_q == CHAR_TAB) ||
                    (byte_q == CHAR_VT) || (byte_q == CHAR_FF);
  assign is_sign  = (byte_q == CHAR_PLUS) || (byte_q == CHAR_MINUS);
  assign is_digit = (byte_q >= CHAR_ZERO) && (byte_q <= CHAR_NINE);

  // magnitude * 10 + digit, saturating; magnitude <= 101 keeps this in 10 bits
  assign mag_ext  = ACC_W'(mag_q);
  assign acc      = (mag_ext << 3) + (mag_ext << 1) +
                    ACC_W'(byte_q[3:0]);
  assign mag_next = (acc > ACC_W'(MAG_SAT)) ? MAG_SAT : acc[MAG_W-1:0];

  // value of the closed line
  assign duty      = neg_q ? '0 : ((mag_q > DUTY_MAX) ? DUTY_MAX : mag_q);
  assign letter_up = letter_q & UPPER_MASK;

  // a line end with at least one stored byte gives a result
  assign emit = proc && is_eol && (cnt_q != '0);

  // line state next value
  always_comb begin
    cnt_d    = cnt_q;
    letter_d = letter_q;
    phase_d  = phase_q;
    neg_d    = neg_q;
    mag_d    = mag_q;
    if (proc && !is_eol && (cnt_q != CNT_LAST)) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == '0) begin
        letter_d = byte_q;
      end else begin
        unique case (phase_q)
          PHASE_SPACE: begin
            priority if (is_space) begin
              phase_d = PHASE_SPACE;
            end else if (is_sign) begin
              neg_d   = (byte_q == CHAR_MINUS);
              phase_d = PHASE_DIGITS;
            end else if (is_digit) begin
              mag_d   = mag_next;
              phase_d = PHASE_DIGITS;
            end else begin
              phase_d = PHASE_DONE;
            end
          end
          PHASE_DIGITS: begin
            if (is_digit) begin
              mag_d = mag_next;
            end else begin
              phase_d = PHASE_DONE;
            end
          end
          PHASE_DONE: phase_d = PHASE_DONE;
          default:    phase_d = PHASE_DONE;
        endcase
      end
    end else if (emit) begin
      // clear the line for the next command
      cnt_d    = '0;
      letter_d = '0;
      phase_d  = PHASE_SPACE;
      neg_d    = 1'b0;
      mag_d    = '0;
    end
  end

  // duty update and result
  always_comb begin
    red_d     = red_q;
    green_d   = green_q;
    blue_d    = blue_q;
    status_d  = status_q;
    res_vld_d = advance ? emit : res_vld_q;
    if (emit) begin
      status_d = STATUS_APPLIED;
      priority if (letter_up == CHAR_R) begin
        red_d = duty;
      end else if (letter_up == CHAR_G) begin
        green_d = duty;
      end else if (letter_up == CHAR_B) begin
        blue_d = duty;
      end else begin
        status_d = STATUS_BAD_LETTER;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
      cnt_q      <= '0;
      letter_q   <= '0;
      phase_q    <= PHASE_SPACE;
      neg_q      <= 1'b0;
      mag_q      <= '0;
      red_q      <= '0;
      green_q    <= '0;
      blue_q     <= '0;
      res_vld_q  <= 1'b0;
      status_q   <= STATUS_APPLIED;
    end else begin
      byte_vld_q <= byte_vld_d;
      cnt_q      <= cnt_d;
      letter_q   <= letter_d;
      phase_q    <= phase_d;
      neg_q      <= neg_d;
      mag_q      <= mag_d;
      red_q      <= red_d;
      green_q    <= green_d;
      blue_q     <= blue_d;
      res_vld_q  <= res_vld_d;
      status_q   <= status_d;
    end
  end

  // payload register of the input stage
  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  // duties change only on a result, and a result is made only once the
  // previous one has left, so the level registers double as the payload
  assign res_o.valid      = res_vld_q;
  assign res_o.red_duty   = red_q;
  assign res_o.green_duty = green_q;
  assign res_o.blue_duty  = blue_q;
  assign res_o.status     = status_q;

endmodule

`default_nettype wire

/* verif/srdcp_duty_checker.sv */
// ----------------------------------------------------------------------------
// srdcp_duty_checker
// watches the byte and result channels of the command parser, tracks the
// line state and the duties, and checks each result transaction
// ----------------------------------------------------------------------------
`default_nettype none

module srdcp_duty_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  srdcp_in_if         rx_mon,
  srdcp_out_if        res_mon,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import srdcp_pkg::*;

  typedef struct packed {
    logic [DUTY_W-1:0] red;
    logic [DUTY_W-1:0] green;
    logic [DUTY_W-1:0] blue;
    status_e           status;
  } duty_result_t;

  duty_result_t duty_expect_q[$];
  int unsigned  mismatch_cnt = 0;
  int unsigned  owed_cnt     = 0;

  // line state
  logic [CNT_W-1:0]  line_len;
  logic [BYTE_W-1:0] cmd_letter;
  phase_e            num_phase;
  logic              num_neg;
  logic [MAG_W-1:0]  num_mag;
  // duties
  logic [DUTY_W-1:0] red_lvl;
  logic [DUTY_W-1:0] green_lvl;
  logic [DUTY_W-1:0] blue_lvl;

  assign fail_cnt_o = mismatch_cnt;
  assign pending_o  = owed_cnt;

  function void clear_line();
    line_len   = '0;
    cmd_letter = '0;
    num_phase  = PHASE_SPACE;
    num_neg    = 1'b0;
    num_mag    = '0;
  endfunction

  task automatic absorb_rx_byte(input logic [BYTE_W-1:0] c);
    logic              is_ws;
    logic              is_digit;
    logic              taken;
    int unsigned       acc;
    logic [DUTY_W-1:0] duty;
    duty_result_t      res;
    is_ws    = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    taken    = 1'b0;
    if (c != CHAR_CR && c != CHAR_LF) begin
      // bytes past the line capacity are dropped
      if (line_len < CNT_LAST) begin
        if (line_len == '0) begin
          cmd_letter = c;
        end else begin
          if (num_phase == PHASE_SPACE) begin
            if (is_ws) begin
              taken = 1'b1;
            end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
              num_neg   = (c == CHAR_MINUS);
              num_phase = PHASE_DIGITS;
              taken     = 1'b1;
            end else begin
              num_phase = PHASE_DIGITS;
            end
          end
          if (!taken && num_phase == PHASE_DIGITS) begin
            if (is_digit) begin
              acc     = num_mag * 10 + (c - CHAR_ZERO);
              num_mag = (acc > MAG_SAT) ? MAG_SAT : MAG_W'(acc);
            end else begin
              num_phase = PHASE_DONE;
            end
          end
        end
        line_len++;
      end
    end else if (line_len != '0) begin
      if (num_neg) begin
        duty = '0;
      end else begin
        duty = (num_mag > DUTY_MAX) ? DUTY_MAX : num_mag;
      end
      res.status = STATUS_APPLIED;
      case (cmd_letter & UPPER_MASK)
        CHAR_R:  red_lvl   = duty;
        CHAR_G:  green_lvl = duty;
        CHAR_B:  blue_lvl  = duty;
        default: res.status = STATUS_BAD_LETTER;
      endcase
      res.red   = red_lvl;
      res.green = green_lvl;
      res.blue  = blue_lvl;
      duty_expect_q.push_back(res);
      clear_line();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    duty_result_t want;
    if (!rst_ni) begin
      clear_line();
      red_lvl   = '0;
      green_lvl = '0;
      blue_lvl  = '0;
      duty_expect_q.delete();
    end else begin
      // results leave before the byte of this edge can change anything
      if (res_mon.valid && res_mon.ready) begin
        if (duty_expect_q.size() == 0) begin
          $error("result with no line end waiting: red %0d green %0d blue %0d status %0d",
                 res_mon.red_duty, res_mon.green_duty, res_mon.blue_duty, res_mon.status);
          mismatch_cnt++;
        end else begin
          want = duty_expect_q.pop_front();
          if (res_mon.red_duty !== want.red) begin
            $error("red_duty expected %0d got %0d", want.red, res_mon.red_duty);
            mismatch_cnt++;
          end
          if (res_mon.green_duty !== want.green) begin
            $error("green_duty expected %0d got %0d", want.green, res_mon.green_duty);
            mismatch_cnt++;
          end
          if (res_mon.blue_duty !== want.blue) begin
            $error("blue_duty expected %0d got %0d", want.blue, res_mon.blue_duty);
            mismatch_cnt++;
          end
          if (res_mon.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, res_mon.status);
            mismatch_cnt++;
          end
        end
      end
      if (rx_mon.valid && rx_mon.ready) begin
        absorb_rx_byte(rx_mon.rx_byte);
      end
    end
    owed_cnt = duty_expect_q.size();
  end

endmodule

`default_nettype wire

/* verif/serial_rgb_duty_command_parser_unit_tb.sv */
// ----------------------------------------------------------------------------
// serial_rgb_duty_command_parser_unit_tb
// drives command lines into the parser and checks every result transaction
// against an independent model of the line parsing and the duty registers
// ----------------------------------------------------------------------------
`default_nettype none

module serial_rgb_duty_command_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srdcp_pkg::*;

  // quiet cycles before the run is declared hung
  localparam int unsigned WATCHDOG_LIMIT   = 2000;
  // receiver hold-off that lets the parser fill up and stall its input
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  // random bytes per traffic phase
  localparam int unsigned PHASE_BYTES      = 245;
  localparam int unsigned NUM_PHASES       = 5;

  // per phase: sender idle and receiver stall, in percent
  localparam int unsigned SEND_IDLE_PCT [NUM_PHASES] = '{0, 68, 0, 36, 0};
  localparam int unsigned RES_STALL_PCT [NUM_PHASES] = '{0, 0, 68, 36, 0};
  // phase that runs the long receiver hold-off
  localparam int unsigned PRESSURE_PHASE = 4;

  localparam logic [BYTE_W-1:0] LOWER_BIT = ~UPPER_MASK;
  localparam logic [BYTE_W-1:0] CHAR_NUL  = 8'h00;

  // directed lines
  //   R100       top of the range
  //   g999       lower-case letter, large number saturates
  //   b-7        negative number gives zero
  //   (empty)    bare line end, no result
  //   G          letter with no digits gives zero
  //   nul        zero byte as letter is an unknown command
  //   r5 nul 9   zero byte ends the number
  localparam logic [BYTE_W-1:0] DIRECTED_BYTES [24] = '{
    CHAR_R, CHAR_ZERO + 8'd1, CHAR_ZERO, CHAR_ZERO, CHAR_LF,
    CHAR_G | LOWER_BIT, CHAR_NINE, CHAR_NINE, CHAR_NINE, CHAR_CR,
    CHAR_B | LOWER_BIT, CHAR_MINUS, CHAR_ZERO + 8'd7, CHAR_LF,
    CHAR_CR,
    CHAR_G, CHAR_LF,
    CHAR_NUL, CHAR_CR,
    CHAR_R | LOWER_BIT, CHAR_ZERO + 8'd5, CHAR_NUL, CHAR_NINE, CHAR_LF
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  srdcp_in_if  rx_if ();
  srdcp_out_if res_if ();

  int unsigned fail_cnt;
  int unsigned expect_cnt;

  // traffic shaping, written by the stimulus process; quiet_cycles is kept by the watchdog
  int unsigned send_idle_pct = 0;
  int unsigned res_stall_pct = 0;
  int unsigned hold_req_cnt  = 0;
  int unsigned bytes_sent    = 0;
  int unsigned quiet_cycles  = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  serial_rgb_duty_command_parser_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  srdcp_duty_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_mon     (rx_if),
    .res_mon    (res_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (expect_cnt)
  );

  // one byte transaction; returns just after the accepting edge
  task automatic push_rx_byte(input logic [BYTE_W-1:0] b);
    @(negedge clk_i);
    // random sender gaps, one draw per cycle
    while ($urandom_range(99) < send_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    bytes_sent++;
  endtask

  // one random line: mostly well-formed commands with random content,
  // some raw noise and some bare line ends
  task automatic emit_random_line();
    logic [BYTE_W-1:0] line_q[$];
    logic [BYTE_W-1:0] digit_q[$];
    logic [BYTE_W-1:0] b;
    int unsigned       kind;
    int unsigned       val;
    int unsigned       n;
    kind = $urandom_range(99);
    if (kind < 8) begin
      // noise, any byte value, line ends included
      n = $urandom_range(20, 1);
      repeat (n) line_q.push_back(BYTE_W'($urandom_range(255)));
    end else if (kind >= 12) begin
      // command letter, mostly a known one in either case
      case ($urandom_range(7))
        0:       b = CHAR_R;
        1:       b = CHAR_G;
        2:       b = CHAR_B;
        3:       b = CHAR_R | LOWER_BIT;
        4:       b = CHAR_G | LOWER_BIT;
        5:       b = CHAR_B | LOWER_BIT;
        default: b = BYTE_W'($urandom_range(255));
      endcase
      line_q.push_back(b);
      // leading whitespace of all four kinds
      repeat ($urandom_range(2)) begin
        case ($urandom_range(3))
          0:       line_q.push_back(CHAR_SPACE);
          1:       line_q.push_back(CHAR_TAB);
          2:       line_q.push_back(CHAR_VT);
          default: line_q.push_back(CHAR_FF);
        endcase
      end
      case ($urandom_range(3))
        0:       line_q.push_back(CHAR_PLUS);
        1:       line_q.push_back(CHAR_MINUS);
        default: ;
      endcase
      // number, sometimes left out
      if ($urandom_range(9) != 0) begin
        case ($urandom_range(3))
          0:       val = $urandom_range(100);
          1:       val = $urandom_range(105, 95);
          2:       val = $urandom_range(99999);
          default: val = $urandom_range(9);
        endcase
        do begin
          digit_q.push_front(CHAR_ZERO + BYTE_W'(val % 10));
          val = val / 10;
        end while (val != 0);
        if ($urandom_range(7) == 0) digit_q.push_front(CHAR_ZERO);
        line_q = {line_q, digit_q};
      end
      // trailing junk after the number, line ends kept out
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(4, 1)) begin
          b = BYTE_W'($urandom_range(255));
          if (b == CHAR_CR || b == CHAR_LF) b = CHAR_SPACE;
          line_q.push_back(b);
        end
      end
      // overlong line, the tail past capacity must be dropped
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(20, 10)) begin
          line_q.push_back(CHAR_ZERO + BYTE_W'($urandom_range(9)));
        end
      end
    end
    line_q.push_back($urandom_range(1) ? CHAR_CR : CHAR_LF);
    foreach (line_q[i]) push_rx_byte(line_q[i]);
  endtask

  // stimulus and verdict
  initial begin
    int unsigned phase_idx;
    int unsigned budget;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    rst_ni        = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED_BYTES[i]) push_rx_byte(DIRECTED_BYTES[i]);

    for (phase_idx = 0; phase_idx < NUM_PHASES; phase_idx++) begin
      send_idle_pct = SEND_IDLE_PCT[phase_idx];
      res_stall_pct = RES_STALL_PCT[phase_idx];
      // ask the receiver for a long hold-off while bytes keep coming
      if (phase_idx == PRESSURE_PHASE) hold_req_cnt++;
      budget = bytes_sent + PHASE_BYTES;
      while (bytes_sent < budget) emit_random_line();
    end

    @(negedge clk_i);
    rx_if.valid <= 1'b0;

    // drain, then wait for any stray result
    do @(negedge clk_i); while (expect_cnt != 0);
    repeat (8) @(negedge clk_i);

    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // result receiver: random stalls, plus the long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_req_cnt) begin
        hold_seen = hold_req_cnt;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= res_stall_pct);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
